// ----- design/ndpcm_pkg.sv -----
// Shared types and constants for the nibble DPCM block decoder.
// No dependencies; used by ndpcm_delta_acc, nibble_dpcm_block_decoder, ndpcm_checker and the testbench.
`default_nettype none

package ndpcm_pkg;

  // Datapath widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  // Low nibble sits in the top of the word and is shifted right by (28 - s) mod 32
  localparam logic [SHIFT_W-1:0] LO_SHIFT_BASE = 5'd28;

  // Clamp limits of the accumulator, compared on the 32-bit sum
  localparam logic signed [WORD_W-1:0] SUM_MAX = 32'sd32767;
  localparam logic signed [WORD_W-1:0] SUM_MIN = -32'sd32768;
  localparam logic signed [ACC_W-1:0]  ACC_MAX = 16'sh7fff;
  localparam logic signed [ACC_W-1:0]  ACC_MIN = -16'sh8000;

  // Byte position within a block: header, then eight data bytes
  localparam logic [POS_W-1:0] HDR_POS       = 4'd0;
  localparam logic [POS_W-1:0] FIRST_DAT_POS = 4'd1;
  localparam logic [POS_W-1:0] LAST_DAT_POS  = 4'd8;

  // Register map
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 24'd1;

  // Request from the control path to the delta/accumulate datapath
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [SHIFT_W-1:0] shift;
    logic               high_phase;  // 0: low nibble, 1: high nibble
  } step_req_t;

endpackage

`default_nettype wire

// ----- design/ndpcm_delta_acc.sv -----
// Delta generation, 32-bit wrapping add and 16-bit clamp for one sample.
// Depends on ndpcm_pkg.
`default_nettype none

module ndpcm_delta_acc (
  input  wire ndpcm_pkg::step_req_t                req,
  input  wire logic signed [ndpcm_pkg::ACC_W-1:0]  acc_i,
  output logic signed [ndpcm_pkg::ACC_W-1:0]       acc_o
);

  logic [ndpcm_pkg::NIB_W-1:0]          nib;
  logic [ndpcm_pkg::SHIFT_W-1:0]        lo_k;
  logic signed [ndpcm_pkg::WORD_W-1:0]  lo_word;
  logic signed [ndpcm_pkg::WORD_W-1:0]  lo_delta;
  logic signed [ndpcm_pkg::WORD_W-1:0]  hi_delta;
  logic signed [ndpcm_pkg::WORD_W-1:0]  delta;
  logic signed [ndpcm_pkg::WORD_W-1:0]  sum;

  // Pick the nibble for this phase
  assign nib = req.high_phase ? req.data_byte[7:4] : req.data_byte[3:0];

  // Low nibble: top of word, arithmetic shift right by (28 - s) mod 32
  assign lo_k     = ndpcm_pkg::SHIFT_W'(ndpcm_pkg::LO_SHIFT_BASE - req.shift);
  assign lo_word  = {nib, {(ndpcm_pkg::WORD_W - ndpcm_pkg::NIB_W){1'b0}}};
  assign lo_delta = lo_word >>> lo_k;

  // High nibble: sign-extended, shifted left by s
  assign hi_delta = {{(ndpcm_pkg::WORD_W - ndpcm_pkg::NIB_W){nib[3]}}, nib} << req.shift;

  assign delta = req.high_phase ? hi_delta : lo_delta;

  // Wrapping add on 32 bits
  assign sum = ndpcm_pkg::WORD_W'(
               {{(ndpcm_pkg::WORD_W - ndpcm_pkg::ACC_W){acc_i[ndpcm_pkg::ACC_W-1]}}, acc_i}
               + delta);

  // Clamp into 16-bit range
  always_comb begin
    if (sum > ndpcm_pkg::SUM_MAX) begin
      acc_o = ndpcm_pkg::ACC_MAX;
    end else if (sum < ndpcm_pkg::SUM_MIN) begin
      acc_o = ndpcm_pkg::ACC_MIN;
    end else begin
      acc_o = sum[ndpcm_pkg::ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/nibble_dpcm_block_decoder.sv -----
// Nibble DPCM block decoder top level: input register, control, result register.
// Depends on ndpcm_pkg and ndpcm_delta_acc.
//
// Usage:
// - Input channel (in_valid/in_ready/in_data_byte) takes a byte stream of 9-byte
//   blocks: a shift header followed by eight data bytes, two nibbles each.
// - Result channel (out_valid/out_ready) gives out_sample_high, the high byte
//   of the clamped accumulator, and out_last_of_pair, set on the high nibble.
// - APB-style port: block_count at byte address 0; the user must write it only
//   while idle, the block has no guard for it. A transfer lands in an input
//   register; the next cycle a header byte is absorbed, and a data byte passes
//   the single add-and-clamp path once per sample, each to the result register.
// - Path: a data byte waits in the input register and each of its samples is
//   registered in the result register, low nibble first, then high.
// - Throughput: a header byte yields no sample, a data byte yields two; the
//   accumulator loop produces one sample per cycle while the receiver keeps up.
// - The next byte is taken while a result waits in the result register.
// - When the receiver stalls, the result register holds its sample, a data byte
//   in the input register waits and keeps in_ready low; a header still passes.
// - Reset (synchronous, rst_n low) empties both registers, clears accumulator,
//   block position and run counter, and sets block_count to 1.
`default_nettype none

module nibble_dpcm_block_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ndpcm_pkg::BYTE_W-1:0]      in_data_byte,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ndpcm_pkg::BYTE_W-1:0]    out_sample_high,
  output logic                                   out_last_of_pair,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [ndpcm_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [ndpcm_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [ndpcm_pkg::DATA_W-1:0]           cfg_prdata,
  output logic                                   cfg_pready
);

  // Configuration
  logic [ndpcm_pkg::CNT_W-1:0]         block_count_r;
  logic                                cfg_sel_bc;
  logic                                cfg_wr;

  // Input register
  logic                                hold_vld_r;
  logic [ndpcm_pkg::BYTE_W-1:0]        hold_byte_r;
  logic                                phase_r;

  // Decoder state
  logic [ndpcm_pkg::POS_W-1:0]         pos_r;
  logic [ndpcm_pkg::SHIFT_W-1:0]       shift_r;
  logic signed [ndpcm_pkg::ACC_W-1:0]  acc_r;
  logic [ndpcm_pkg::CNT_W-1:0]         done_r;

  // Result register
  logic                                out_vld_r;
  logic signed [ndpcm_pkg::BYTE_W-1:0] out_sample_r;
  logic                                out_last_r;

  // Control
  logic                                is_hdr;
  logic                                out_free;
  logic                                step;
  logic                                consume;
  logic                                data_step;
  logic                                blk_end;
  logic [ndpcm_pkg::CNT_W-1:0]         done_inc;
  logic                                run_end;
  ndpcm_pkg::step_req_t                req;
  logic signed [ndpcm_pkg::ACC_W-1:0]  acc_new;

  // Register access
  assign cfg_pready = 1'b1;
  assign cfg_sel_bc = (cfg_paddr[2] == ndpcm_pkg::REG_BLOCK_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_bc;
  assign cfg_prdata = cfg_sel_bc ?
                      {{(ndpcm_pkg::DATA_W - ndpcm_pkg::CNT_W){1'b0}}, block_count_r} :
                      '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= ndpcm_pkg::BLOCK_COUNT_RST;
    end else if (cfg_wr) begin
      block_count_r <= cfg_pwdata[ndpcm_pkg::CNT_W-1:0];
    end
  end

  // Step control: a header is absorbed without waiting, a data byte emits low then high
  assign is_hdr    = (pos_r == ndpcm_pkg::HDR_POS);
  assign out_free  = !out_vld_r || out_ready;
  assign step      = hold_vld_r && (is_hdr || out_free);
  assign data_step = step && !is_hdr;
  assign consume   = step && (is_hdr || phase_r);
  assign in_ready  = !hold_vld_r || consume;

  // End of block and end of run
  assign blk_end  = data_step && phase_r && (pos_r >= ndpcm_pkg::LAST_DAT_POS);
  assign done_inc = ndpcm_pkg::CNT_W'(done_r + 1'b1);
  assign run_end  = (done_inc == block_count_r);

  // Datapath
  assign req.data_byte  = hold_byte_r;
  assign req.shift      = shift_r;
  assign req.high_phase = phase_r;

  ndpcm_delta_acc u_delta_acc (
    .req   (req),
    .acc_i (acc_r),
    .acc_o (acc_new)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_vld_r <= 1'b1;
      end else if (consume) begin
        hold_vld_r <= 1'b0;
      end
      if (data_step) begin
        phase_r <= !phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_data_byte;
    end
  end

  // Block position, shift, accumulator and run counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= ndpcm_pkg::HDR_POS;
      shift_r <= '0;
      acc_r   <= '0;
      done_r  <= '0;
    end else if (step) begin
      if (is_hdr) begin
        shift_r <= hold_byte_r[ndpcm_pkg::SHIFT_W-1:0];
        pos_r   <= ndpcm_pkg::FIRST_DAT_POS;
      end else begin
        acc_r <= acc_new;
        if (phase_r) begin
          if (blk_end) begin
            pos_r <= ndpcm_pkg::HDR_POS;
            if (run_end) begin
              done_r <= '0;
              acc_r  <= '0;
            end else begin
              done_r <= done_inc;
            end
          end else begin
            pos_r <= ndpcm_pkg::POS_W'(pos_r + 1'b1);
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (data_step) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_step) begin
      out_sample_r <= acc_new[ndpcm_pkg::ACC_W-1 -: ndpcm_pkg::BYTE_W];
      out_last_r   <= phase_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_sample_high  = out_sample_r;
  assign out_last_of_pair = out_last_r;

endmodule

`default_nettype wire

// ----- design/ndpcm_checker.sv -----
// Port-level checker for the nibble DPCM block decoder, with its bind.
// Depends on ndpcm_pkg and the nibble_dpcm_block_decoder ports.
`default_nettype none

module ndpcm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [ndpcm_pkg::BYTE_W-1:0]      in_data_byte,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [ndpcm_pkg::BYTE_W-1:0] out_sample_high,
  input wire logic                              out_last_of_pair,
  input wire logic                              cfg_psel,
  input wire logic                              cfg_penable,
  input wire logic                              cfg_pwrite,
  input wire logic [ndpcm_pkg::ADDR_W-1:0]      cfg_paddr,
  input wire logic [ndpcm_pkg::DATA_W-1:0]      cfg_pwdata,
  input wire logic [ndpcm_pkg::DATA_W-1:0]      cfg_prdata,
  input wire logic                              cfg_pready
);

  // A stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_high)
                                && $stable(out_last_of_pair))
    else $error("result changed while stalled");

  // A waiting input byte stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte))
    else $error("input byte changed while waiting");

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("decoder not empty after reset");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

  // A written block_count reads back at the same address
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]
    |=> (cfg_paddr != $past(cfg_paddr))
        || (cfg_prdata[ndpcm_pkg::CNT_W-1:0] == $past(cfg_pwdata[ndpcm_pkg::CNT_W-1:0])))
    else $error("block_count readback mismatch");

endmodule

bind nibble_dpcm_block_decoder ndpcm_checker u_ndpcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_data_byte     (in_data_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sample_high  (out_sample_high),
  .out_last_of_pair (out_last_of_pair),
  .cfg_psel         (cfg_psel),
  .cfg_penable      (cfg_penable),
  .cfg_pwrite       (cfg_pwrite),
  .cfg_paddr        (cfg_paddr),
  .cfg_pwdata       (cfg_pwdata),
  .cfg_prdata       (cfg_prdata),
  .cfg_pready       (cfg_pready)
);

`default_nettype wire

// ----- tb/nibble_dpcm_block_decoder_tb.sv -----
// Self-checking testbench for nibble_dpcm_block_decoder: byte stream in, samples out.
// Depends on ndpcm_pkg and the decoder RTL; a tracker class predicts every sample.
// Random idling on both channels, a long receiver hold-off, block_count over its range.
`default_nettype none

module nibble_dpcm_block_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GAP_MAX       = 17;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [ndpcm_pkg::ADDR_W-1:0] COUNT_ADDR =
    ndpcm_pkg::ADDR_W'(ndpcm_pkg::REG_BLOCK_COUNT) << 2;
  localparam logic [ndpcm_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;  // register index 1: empty

  // One expected sample
  typedef struct packed {
    logic signed [ndpcm_pkg::BYTE_W-1:0] sample_high;
    logic                                last_of_pair;
  } sample_t;

  // Tracks decoder state, predicts samples and matches them on arrival
  class dpcm_tracker;
    logic [ndpcm_pkg::CNT_W-1:0]        count;
    logic [ndpcm_pkg::POS_W-1:0]        pos;
    logic [ndpcm_pkg::SHIFT_W-1:0]      shift;
    logic signed [ndpcm_pkg::ACC_W-1:0] acc;
    logic [ndpcm_pkg::CNT_W-1:0]        blocks_done;
    sample_t                            pending_samples[$];
    int errors, n_bytes, n_headers, n_samples, n_restarts, n_top, n_bottom;

    function new();
      count = ndpcm_pkg::BLOCK_COUNT_RST;
      pos = ndpcm_pkg::HDR_POS;
      shift = '0;
      acc = '0;
      blocks_done = '0;
    endfunction

    function void set_count(logic [ndpcm_pkg::DATA_W-1:0] value);
      count = value[ndpcm_pkg::CNT_W-1:0];
    endfunction

    // Add one delta with 32-bit wrap, clamp to 16 bits, queue the high byte
    function void accumulate(logic signed [ndpcm_pkg::WORD_W-1:0] delta, logic last);
      logic signed [ndpcm_pkg::WORD_W-1:0] total;
      sample_t s;
      total = {{(ndpcm_pkg::WORD_W-ndpcm_pkg::ACC_W){acc[ndpcm_pkg::ACC_W-1]}}, acc}
              + delta;
      if (total > ndpcm_pkg::SUM_MAX) begin
        acc = ndpcm_pkg::ACC_MAX;
        n_top++;
      end else if (total < ndpcm_pkg::SUM_MIN) begin
        acc = ndpcm_pkg::ACC_MIN;
        n_bottom++;
      end else begin
        acc = total[ndpcm_pkg::ACC_W-1:0];
      end
      s.sample_high = acc[ndpcm_pkg::ACC_W-1:ndpcm_pkg::ACC_W-ndpcm_pkg::BYTE_W];
      s.last_of_pair = last;
      pending_samples = {pending_samples, s};
    endfunction

    // Accepted input byte: header sets the shift, data byte yields two samples
    function void take_byte(logic [ndpcm_pkg::BYTE_W-1:0] b);
      logic signed [ndpcm_pkg::WORD_W-1:0] lo_word, lo, hi;
      logic [ndpcm_pkg::SHIFT_W-1:0] lo_shift;
      n_bytes++;
      if (pos == ndpcm_pkg::HDR_POS) begin
        shift = b[ndpcm_pkg::SHIFT_W-1:0];
        pos = ndpcm_pkg::FIRST_DAT_POS;
        n_headers++;
        return;
      end
      lo_word = {b[ndpcm_pkg::NIB_W-1:0], {(ndpcm_pkg::WORD_W-ndpcm_pkg::NIB_W){1'b0}}};
      lo_shift = ndpcm_pkg::LO_SHIFT_BASE - shift;
      lo = lo_word >>> lo_shift;
      hi = {{(ndpcm_pkg::WORD_W-ndpcm_pkg::NIB_W){b[ndpcm_pkg::BYTE_W-1]}},
            b[ndpcm_pkg::BYTE_W-1:ndpcm_pkg::NIB_W]} << shift;
      accumulate(lo, 1'b0);
      accumulate(hi, 1'b1);
      // block end, and run end when the count is reached
      if (pos == ndpcm_pkg::LAST_DAT_POS) begin
        pos = ndpcm_pkg::HDR_POS;
        blocks_done = blocks_done + 1'b1;
        if (blocks_done == count) begin
          blocks_done = '0;
          acc = '0;
          n_restarts++;
        end
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    function void match_sample(logic signed [ndpcm_pkg::BYTE_W-1:0] sample_high,
                               logic last_of_pair);
      sample_t e;
      n_samples++;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample: sample_high %0d, last_of_pair %0b",
               sample_high, last_of_pair);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (sample_high !== e.sample_high) begin
        $error("sample_high: expected %0d, actual %0d", e.sample_high, sample_high);
        errors++;
      end
      if (last_of_pair !== e.last_of_pair) begin
        $error("last_of_pair: expected %0b, actual %0b", e.last_of_pair, last_of_pair);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ndpcm_pkg::BYTE_W-1:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ndpcm_pkg::BYTE_W-1:0] out_sample_high;
  logic out_last_of_pair;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ndpcm_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [ndpcm_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [ndpcm_pkg::DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  bit idle_in_on = 1'b1;
  bit idle_out_on = 1'b1;
  int unsigned hold_left = 0;
  int n_writes = 0;

  dpcm_tracker sb = new();

  nibble_dpcm_block_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_high  (out_sample_high),
    .out_last_of_pair (out_last_of_pair),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver hold-off counter
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result side: random stalls, hold-off, check each transfer
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = idle_out_on ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0 || hold_left != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_left != 0) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.match_sample(out_sample_high, out_last_of_pair);
    end
  end

  // One input transfer after a random gap
  task automatic send_byte(input logic [ndpcm_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    gap = idle_in_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
  endtask

  // Random blocks: headers lean to small shifts so samples do not always clamp
  task automatic send_random(input int n);
    logic [ndpcm_pkg::BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 39) begin
        idle_in_on = $urandom_range(0, 3) != 0;
        idle_out_on = $urandom_range(0, 3) != 0;
      end
      b = 8'($urandom_range(0, 255));
      if (sb.pos == ndpcm_pkg::HDR_POS && $urandom_range(0, 2) != 0)
        b[ndpcm_pkg::SHIFT_W-1:0] = 5'($urandom_range(0, 12));
      send_byte(b);
    end
  endtask

  // Stop offering, wait for every expected sample, then let a pending header settle
  task automatic drain();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.pending_samples.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB access: setup cycle, access until pready, then back to idle
  task automatic reg_access(input logic wr, input logic [ndpcm_pkg::ADDR_W-1:0] addr,
                            input logic [ndpcm_pkg::DATA_W-1:0] wdata,
                            output logic [ndpcm_pkg::DATA_W-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, then read block_count back
  task automatic program_reg(input logic [ndpcm_pkg::ADDR_W-1:0] addr,
                             input logic [ndpcm_pkg::DATA_W-1:0] value);
    logic [ndpcm_pkg::DATA_W-1:0] rd;
    reg_access(1'b1, addr, value, rd);
    n_writes++;
    if (addr == COUNT_ADDR) sb.set_count(value);
    reg_access(1'b0, COUNT_ADDR, '0, rd);
    if (rd[ndpcm_pkg::CNT_W-1:0] !== sb.count) begin
      $error("block_count: expected %0d, actual %0d", sb.count, rd[ndpcm_pkg::CNT_W-1:0]);
      sb.errors++;
    end
  endtask

  initial begin
    logic [ndpcm_pkg::BYTE_W-1:0] directed[25] = '{
      8'h00, 8'h00, 8'h77, 8'h88, 8'hFF, 8'h7F, 8'hF7, 8'h80, 8'h08,
      8'hFF, 8'h77, 8'h11, 8'h77, 8'h88, 8'h99, 8'h08, 8'h80, 8'hEE,
      8'hFC, 8'h11, 8'hF8, 8'h7F, 8'h00, 8'h80, 8'hFF
    };
    logic [ndpcm_pkg::DATA_W-1:0] rd;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of block_count, then zero, +/-7 and the shift extremes
    reg_access(1'b0, COUNT_ADDR, '0, rd);
    if (rd[ndpcm_pkg::CNT_W-1:0] !== ndpcm_pkg::BLOCK_COUNT_RST) begin
      $error("block_count: expected %0d, actual %0d", ndpcm_pkg::BLOCK_COUNT_RST,
             rd[ndpcm_pkg::CNT_W-1:0]);
      sb.errors++;
    end
    foreach (directed[i]) send_byte(directed[i]);
    send_random(300);
    drain();

    // short runs; junk above bit 23 and a write to an empty address
    program_reg(COUNT_ADDR, {8'hA5, 24'd6});
    program_reg(UNUSED_ADDR, $urandom);
    send_random(200);
    while (sb.blocks_done != 4) send_random(1);
    drain();

    // count lowered below the blocks already done: run goes on past it
    program_reg(COUNT_ADDR, 32'd2);
    send_random(250);
    drain();

    program_reg(COUNT_ADDR, {8'hFF, {ndpcm_pkg::CNT_W{1'b1}}});
    send_random(200);
    drain();

    program_reg(COUNT_ADDR, 32'd0);
    send_random(200);
    drain();

    // run end reachable again from the current block tally
    program_reg(COUNT_ADDR, 32'(sb.blocks_done) + 3);
    send_random(250);
    drain();

    // back to one block per run; receiver holds off while the sender streams
    program_reg(COUNT_ADDR, 32'd1);
    idle_in_on = 1'b0;
    hold_left <= HOLD_CYCLES;
    send_random(300);
    drain();
    repeat (40) @(posedge clk);

    if (sb.pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", sb.pending_samples.size());
      sb.errors++;
    end
    $display("Sent %0d bytes (%0d block headers) and checked %0d samples over %0d writes.",
             sb.n_bytes, sb.n_headers, sb.n_samples, n_writes);
    $display("Runs restarted %0d times; accumulator clamped %0d times high, %0d low.",
             sb.n_restarts, sb.n_top, sb.n_bottom);
    if (sb.errors == 0) begin
      $display("** nibble_dpcm_block_decoder: PASSED **");
    end else begin
      $display("** nibble_dpcm_block_decoder: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("** nibble_dpcm_block_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/ndpcm_pkg.sv
design/ndpcm_delta_acc.sv
design/nibble_dpcm_block_decoder.sv
design/ndpcm_checker.sv
tb/nibble_dpcm_block_decoder_tb.sv
